// ----- hw/rtl/scaled_signed_divide_round_sat32_core_macros.svh -----
// assertion helpers for the scaled divide core
`ifndef SCALED_SIGNED_DIVIDE_ROUND_SAT32_CORE_MACROS_SVH
`define SCALED_SIGNED_DIVIDE_ROUND_SAT32_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define SSD_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define SSD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssd_pkg.sv -----
package ssd_pkg;

    localparam int NUM_W     = 96;
    localparam int OPND_W    = 64;
    localparam int Q_W       = 32;
    localparam int NSTEPS    = NUM_W;
    localparam logic [5:0] MAX_SHIFT = 6'd32;
    localparam logic [Q_W-1:0] MAG_LIMIT = 32'h7FFF_FFFF;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OVF = 2'd1;
    localparam logic [1:0] STATUS_RNG = 2'd2;

    typedef struct packed {
        logic [OPND_W-1:0] rem;
        logic [NUM_W-1:0]  num;
        logic [Q_W-1:0]    q;
        logic              wide;
        logic [OPND_W-1:0] d;
        logic              neg;
        logic              rng;
        logic              zdiv;
    } stage_t;

    // one restoring division step: brings in the next numerator bit
    function automatic stage_t div_step(input stage_t s);
        stage_t            o;
        logic [OPND_W-1:0] r2;
        logic              ge;
        logic [Q_W:0]      qn;
        o    = s;
        r2   = {s.rem[OPND_W-2:0], s.num[NUM_W-1]};
        ge   = (r2 >= s.d);
        o.rem = ge ? (r2 - s.d) : r2;
        qn   = {s.q, ge};
        o.wide = s.wide | qn[Q_W];
        o.q  = qn[Q_W-1:0];
        o.num = {s.num[NUM_W-2:0], 1'b0};
        return o;
    endfunction

endpackage

// ----- hw/rtl/ssd_if.sv -----
interface ssd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [5:0]  shift_amount;

    modport source (output valid, output dividend, output divisor, output shift_amount,
                    input ready);
    modport sink (input valid, input dividend, input divisor, input shift_amount,
                  output ready);
endinterface

interface ssd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] quotient;
    logic [1:0]  status;

    modport source (output valid, output quotient, output status, input ready);
    modport sink (input valid, input quotient, input status, output ready);
endinterface

// ----- hw/rtl/scaled_signed_divide_round_sat32_core.sv -----
// Scaled signed divider: quotient = round(|dividend| * 2^shift_amount / |divisor|),
// saturated to 2^31-1 in magnitude (status overflow), then signed by the xor of the
// operand signs. A shift above 32 gives 0 with status range error; a zero divisor
// gives 0 with status ok. The core accepts one word every cycle while the output is not
// stalled. The accepting edge loads the operand stage, then the 96-step restoring
// divider computes one quotient bit per stage, and the rounding/output register follows.
// Stalling the output freezes the whole pipeline.
module scaled_signed_divide_round_sat32_core (
    input  logic     clk,
    input  logic     rst_n,
    ssd_in_if.sink   req,
    ssd_out_if.source rsp
);

    localparam int NS = ssd_pkg::NSTEPS;

    ssd_pkg::stage_t st_reg [NS+1];
    logic [NS:0]     valid_reg;
    logic            en;

    ssd_pkg::stage_t front;
    logic [63:0]     ax;
    logic [63:0]     ay;

    logic            out_valid_reg;
    logic [31:0]     quotient_reg;
    logic [1:0]      status_reg;
    logic [31:0]     quotient_next;
    logic [1:0]      status_next;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        ax = req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
        ay = req.divisor[63] ? (64'd0 - req.divisor) : req.divisor;
        front.rem  = '0;
        front.num  = {32'd0, ax} << req.shift_amount[5:0];
        front.q    = '0;
        front.wide = 1'b0;
        front.d    = ay;
        front.neg  = req.dividend[63] ^ req.divisor[63];
        front.rng  = req.shift_amount > ssd_pkg::MAX_SHIFT;
        front.zdiv = (ay == 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NS-1:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= front;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k+1] <= ssd_pkg::div_step(st_reg[k]);
                end
            end
        end
    endgenerate

    // rounding, saturation and sign, plus the range-error and zero-divisor results
    always_comb
    begin
        ssd_pkg::stage_t f;
        logic            rnd;
        logic [32:0]     qr;
        logic            big;
        logic [31:0]     mag;
        f   = st_reg[NS];
        rnd = f.rem >= (f.d - f.rem);
        qr  = {1'b0, f.q} + {32'd0, rnd};
        big = f.wide || (qr > {1'b0, ssd_pkg::MAG_LIMIT});
        mag = big ? ssd_pkg::MAG_LIMIT : qr[31:0];
        if (f.rng)
        begin
            quotient_next = '0;
            status_next   = ssd_pkg::STATUS_RNG;
        end
        else if (f.zdiv)
        begin
            quotient_next = '0;
            status_next   = ssd_pkg::STATUS_OK;
        end
        else
        begin
            quotient_next = f.neg ? (32'd0 - mag) : mag;
            status_next   = big ? ssd_pkg::STATUS_OVF : ssd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quotient_reg <= quotient_next;
            status_reg   <= status_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.quotient = quotient_reg;
    assign rsp.status   = status_reg;

endmodule

// ----- hw/rtl/ssd_checker.sv -----
`include "scaled_signed_divide_round_sat32_core_macros.svh"

module ssd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] quotient,
    input logic [1:0]  status
);

    // a stalled output word holds
    `SSD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(quotient) && $stable(status), "output word changed while stalled")

    // input side stalls exactly when the output is stalled
    `SSD_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

    // saturation never produces the most negative value, and the status code is at most range error
    `SSD_ASSERT_IMPL(a_sat, clk, rst_n, out_valid, quotient != 32'h8000_0000 && status <= ssd_pkg::STATUS_RNG, "bad quotient or status code")

    // range error returns zero
    `SSD_ASSERT_IMPL(a_rng, clk, rst_n, out_valid && status == ssd_pkg::STATUS_RNG, quotient == 32'd0, "range error with nonzero quotient")

endmodule

bind scaled_signed_divide_round_sat32_core ssd_checker u_ssd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .quotient  (rsp.quotient),
    .status    (rsp.status)
);

// ----- tb/scaled_signed_divide_round_sat32_checker.sv -----
`timescale 1ns / 1ps

module scaled_signed_divide_round_sat32_checker (
    input  logic  clk,
    input  logic  rst_n,
    ssd_in_if     req,
    ssd_out_if    rsp,
    output int    fail_count,
    output int    outstanding
);

    typedef struct packed {
        logic [ssd_pkg::Q_W-1:0] quotient;
        logic [1:0]              status;
    } quot_word_t;

    quot_word_t pending_quotients[$];

    function automatic quot_word_t scaled_round_divide(
        input logic [ssd_pkg::OPND_W-1:0] x,
        input logic [ssd_pkg::OPND_W-1:0] y,
        input logic [5:0] s);
        quot_word_t                 w;
        logic [ssd_pkg::OPND_W-1:0] ax;
        logic [ssd_pkg::OPND_W-1:0] ay;
        logic [127:0]               num;
        logic [127:0]               qf;
        logic [127:0]               rm;
        logic [ssd_pkg::Q_W-1:0]    mag;
        w.quotient = '0;
        w.status   = ssd_pkg::STATUS_OK;
        if (s > ssd_pkg::MAX_SHIFT)
        begin
            w.status = ssd_pkg::STATUS_RNG;
            return w;
        end
        // -2^63 negates to itself, which reads as 2^63 unsigned
        ax = x[ssd_pkg::OPND_W-1] ? -x : x;
        ay = y[ssd_pkg::OPND_W-1] ? -y : y;
        if (ay == '0)
            return w;
        num = {64'd0, ax} << s;
        qf  = num / {64'd0, ay};
        rm  = num % {64'd0, ay};
        if (rm >= ({64'd0, ay} - rm))
            qf = qf + 1;
        if (qf > {96'd0, ssd_pkg::MAG_LIMIT})
        begin
            mag      = ssd_pkg::MAG_LIMIT;
            w.status = ssd_pkg::STATUS_OVF;
        end
        else
            mag = qf[ssd_pkg::Q_W-1:0];
        w.quotient = (x[ssd_pkg::OPND_W-1] ^ y[ssd_pkg::OPND_W-1]) ? -mag : mag;
        return w;
    endfunction

    always @(posedge clk)
    begin
        quot_word_t exp_w;
        if (!rst_n)
        begin
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                pending_quotients.push_back(
                    scaled_round_divide(req.dividend, req.divisor, req.shift_amount));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_quotients.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected word: quotient %h status %0d",
                                 rsp.quotient, rsp.status);
                end
                else
                begin
                    exp_w = pending_quotients.pop_front();
                    if (exp_w.quotient !== rsp.quotient || exp_w.status !== rsp.status)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch: expected quotient %h status %0d, got %h %0d",
                                     exp_w.quotient, exp_w.status, rsp.quotient, rsp.status);
                    end
                end
            end
            outstanding = pending_quotients.size();
        end
    end

endmodule

// ----- tb/scaled_signed_divide_round_sat32_core_test.sv -----
`timescale 1ns / 1ps

module scaled_signed_divide_round_sat32_core_test;

    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   cycles;

    ssd_in_if  req_ch ();
    ssd_out_if rsp_ch ();

    scaled_signed_divide_round_sat32_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    scaled_signed_divide_round_sat32_checker quot_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver stall pattern: ready follows one of four randomly chosen modes
    initial
    begin
        int mode;
        int tick;
        rsp_ch.ready = 1'b0;
        mode = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (tick % 64 == 0)
                mode = $urandom_range(0, 3);
            tick = tick + 1;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                2: rsp_ch.ready <= ((tick % 16) >= 12);
                default: rsp_ch.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    task automatic send_word(input logic [63:0] x, input logic [63:0] y,
                             input logic [5:0] s);
        logic ok;
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.dividend     <= x;
        req_ch.divisor      <= y;
        req_ch.shift_amount <= s;
        forever
        begin
            #1;
            ok = req_ch.ready;
            @(posedge clk);
            if (ok)
                break;
            @(negedge clk);
        end
    endtask

    task automatic idle_gap(input int n);
        @(negedge clk);
        req_ch.valid        <= 1'b0;
        req_ch.dividend     <= {$urandom, $urandom};
        req_ch.divisor      <= {$urandom, $urandom};
        req_ch.shift_amount <= $urandom_range(0, 63);
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = v;
            1: v = 64'd0;
            default:
            begin
                v = v >> $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [63:0] x;
        logic [63:0] y;
        logic [5:0]  s;
        int          burst;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.dividend     = '0;
        req_ch.divisor      = '0;
        req_ch.shift_amount = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, rounding ties, zero divisor, shift range edges, saturation
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
        send_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 6'd32);
        send_word(64'h8000_0000_0000_0000, 64'd1, 6'd0);
        send_word(64'd5, 64'h8000_0000_0000_0000, 6'd32);
        send_word(64'd1, 64'd2, 6'd0);
        send_word(64'd3, 64'd2, 6'd0);
        send_word(-64'sd3, 64'd2, 6'd0);
        send_word(-64'sd1, 64'd10, 6'd0);
        send_word(64'd1, -64'sd3, 6'd1);
        send_word(64'd123, 64'd0, 6'd5);
        send_word(64'd123, 64'd7, 6'd33);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd7, 6'd63);
        send_word(64'd0, 64'd9, 6'd32);
        send_word(64'h7FFF_FFFF, 64'd1, 6'd0);
        send_word(64'h8000_0000, 64'd1, 6'd0);
        send_word(-64'sd2147483647, 64'd1, 6'd0);
        send_word(-64'sd2147483648, 64'd1, 6'd0);
        send_word(64'd1, 64'd1, 6'd31);
        send_word(64'd1, -64'sd1, 6'd32);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 6'd32);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, -64'sd1, 6'd32);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 6'd21);

        idle_gap(1);
        while (outstanding != 0)
            @(negedge clk);

        for (int i = 0; i < 400; i = i + burst)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++)
            begin
                x = rand_operand();
                y = rand_operand();
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(0, 32);
                send_word(x, y, s);
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 16));
            if (i > 150 && i < 180)
            begin
                idle_gap(1);
                while (outstanding != 0)
                    @(negedge clk);
            end
        end
        idle_gap(1);

        while (outstanding != 0)
            @(negedge clk);
        repeat (110) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
